### src/ptsch_pkg.sv
// periodic timer scheduler: shared constants, codes and types
// no dependencies; used by ptsch_if, ptsch_outbuf and the top level
`default_nettype none

package ptsch_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W  = 2;
    localparam int MS_W   = 32;
    localparam int ID_W   = 32;
    localparam int NOW_W  = 48;
    localparam int KIND_W = 2;

    // input commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXISTS  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXISTS  = 2'd3;

    // one slot entry in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [NOW_W-1:0] deadline;
        logic [MS_W-1:0]  period;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   result_ident;
        logic              ok;
        logic              last;
    } t_out_item;

    // result beat handed from the sequencer to the output register
    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_push;

endpackage

`default_nettype wire

### src/ptsch_if.sv
// periodic timer scheduler: command and result channel interfaces
// depends on ptsch_pkg
`default_nettype none

interface ptsch_in_if;
    logic                         valid;
    logic                         ready;
    logic [ptsch_pkg::CMD_W-1:0]  cmd;
    logic [ptsch_pkg::MS_W-1:0]   delay_ms;
    logic [ptsch_pkg::MS_W-1:0]   period_ms;
    logic [ptsch_pkg::ID_W-1:0]   timer_ident;

    modport source (output valid, output cmd, output delay_ms, output period_ms,
                    output timer_ident, input ready);
    modport sink   (input valid, input cmd, input delay_ms, input period_ms,
                    input timer_ident, output ready);
endinterface

interface ptsch_out_if;
    logic                         valid;
    logic                         ready;
    logic [ptsch_pkg::KIND_W-1:0] kind;
    logic [ptsch_pkg::ID_W-1:0]   result_ident;
    logic                         ok;
    logic                         last;

    modport source (output valid, output kind, output result_ident, output ok,
                    output last, input ready);
    modport sink   (input valid, input kind, input result_ident, input ok,
                    input last, output ready);
endinterface

`default_nettype wire

### src/ptsch_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ptsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/ptsch_outbuf.sv
// result output register: parts the sequencer from the result channel
// depends on ptsch_pkg and ptsch_if
`default_nettype none

module ptsch_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ptsch_pkg::t_push i_push,
    output logic                  o_push_rdy,
    ptsch_out_if.source           o_rsp
);

    logic                   r_vld;
    ptsch_pkg::t_out_item   r_item;

    assign o_push_rdy = !r_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.vld && o_push_rdy) begin
            r_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld && o_push_rdy) begin
            r_item <= i_push.item;
        end
    end

    assign o_rsp.valid        = r_vld;
    assign o_rsp.kind         = r_item.kind;
    assign o_rsp.result_ident = r_item.result_ident;
    assign o_rsp.ok           = r_item.ok;
    assign o_rsp.last         = r_item.last;

endmodule

`default_nettype wire

### src/periodic_timer_scheduler_core.sv
// periodic timer scheduler top level: command sequencer around the slot memory
// depends on ptsch_pkg, ptsch_if, ptsch_ram and ptsch_outbuf
//
//  channel  | direction | beat
//  ---------+-----------+----------------------------------------------------
//  i_req    | in        | cmd, delay_ms, period_ms, timer_ident
//  o_rsp    | out       | kind, result_ident, ok, last (several per tick)
//
// a tick, destroy or exists walks every slot through the single read port of
// the slot memory, one slot a cycle unless a tick stalls on the result
// channel, and then gives its reply; a tick with nothing due gives no reply
// a create needs no walk: the free slot comes from the valid flops
// synchronous active-low reset clears time and all valid bits and sets the id counter to 1;
// the slot memory itself needs no clearing since valid gates every read
// a stalled result channel holds the walk only when a second fire result is
// due while the output register is still full, and holds the final reply
`default_nettype none

module periodic_timer_scheduler_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptsch_in_if.sink   i_req,
    ptsch_out_if.source o_rsp
);

    localparam int SLOT_W = ptsch_pkg::SLOT_W;
    localparam int NOW_W  = ptsch_pkg::NOW_W;
    localparam int ID_W   = ptsch_pkg::ID_W;
    localparam int MS_W   = ptsch_pkg::MS_W;
    localparam int CNT_W  = ptsch_pkg::CNT_W;
    localparam int NSLOT  = ptsch_pkg::NUM_SLOTS;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [ptsch_pkg::CMD_W-1:0] r_cmd;
    logic [MS_W-1:0]         r_delay;
    logic [MS_W-1:0]         r_period;
    logic [ID_W-1:0]         r_ident;

    logic [NOW_W-1:0]        r_now, n_now;
    logic [ID_W-1:0]         r_next_id, n_next_id;
    logic [NSLOT-1:0]        r_valid, n_valid;

    // walk pipeline: read stage index and evaluate stage
    logic [SLOT_W:0]         r_rd_idx, n_rd_idx;
    logic                    r_ev_vld, n_ev_vld;
    logic [SLOT_W-1:0]       r_ev_idx, n_ev_idx;

    // fire result held back until it is known whether another follows
    logic                    r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]         r_pend_id, n_pend_id;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_found, n_found;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    ptsch_pkg::t_slot_word   ram_wdata;
    logic                    ram_re;
    logic [ptsch_pkg::SLOT_WORD_W-1:0] ram_rdata;
    ptsch_pkg::t_slot_word   rd_word;

    logic                    free_vld;
    logic [SLOT_W-1:0]       free_idx;
    logic                    accept;
    logic                    hit_tick;
    logic                    hit_id;
    logic                    stall;
    logic                    rd_more;
    logic [ID_W-1:0]         id_inc;
    ptsch_pkg::t_push        push;
    logic                    push_rdy;

    assign rd_word = ptsch_pkg::t_slot_word'(ram_rdata);
    assign accept  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign id_inc  = r_next_id + 32'd1;
    assign rd_more = (r_rd_idx != (SLOT_W+1)'(NSLOT));

    // lowest free slot from the valid flops
    always_comb begin
        free_vld = 1'b0;
        free_idx = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_vld = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // slot under evaluation is due; the result cap only bites above 16 slots
    assign hit_tick = r_ev_vld && r_valid[r_ev_idx]
                      && (rd_word.deadline <= r_now)
                      && (r_cnt != CNT_W'(ptsch_pkg::MAX_RESULTS));
    // first live slot holding the id asked about
    assign hit_id   = r_ev_vld && r_valid[r_ev_idx]
                      && (rd_word.ident == r_ident) && !r_found;
    assign stall    = (r_state == ST_SCAN) && (r_cmd == ptsch_pkg::CMD_TICK)
                      && hit_tick && r_pend_vld && !push_rdy;

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_next_id  = r_next_id;
        n_valid    = r_valid;
        n_rd_idx   = r_rd_idx;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_cnt      = r_cnt;
        n_found    = r_found;
        ram_we     = 1'b0;
        ram_waddr  = r_ev_idx;
        ram_wdata  = rd_word;
        ram_re     = 1'b0;
        push       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rd_idx   = '0;
                    n_ev_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    if (i_req.cmd == ptsch_pkg::CMD_CREATE) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                    if (i_req.cmd == ptsch_pkg::CMD_TICK) begin
                        n_now = r_now + 48'd1;
                    end
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    ram_re   = rd_more;
                    n_ev_vld = rd_more;
                    n_ev_idx = r_rd_idx[SLOT_W-1:0];
                    if (rd_more) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end

                    if (r_cmd == ptsch_pkg::CMD_TICK) begin
                        if (hit_tick) begin
                            // release the held result, this one is not the last
                            push.vld               = r_pend_vld;
                            push.item.kind         = ptsch_pkg::KIND_FIRE;
                            push.item.result_ident = r_pend_id;
                            push.item.ok           = 1'b1;
                            push.item.last         = 1'b0;
                            n_pend_vld = 1'b1;
                            n_pend_id  = rd_word.ident;
                            n_cnt      = r_cnt + 1'b1;
                            if (rd_word.period != '0) begin
                                ram_we             = 1'b1;
                                ram_wdata.deadline = rd_word.deadline
                                                     + {16'd0, rd_word.period};
                            end else begin
                                n_valid[r_ev_idx] = 1'b0;
                            end
                        end
                    end else if (hit_id) begin
                        n_found = 1'b1;
                        if (r_cmd == ptsch_pkg::CMD_DESTROY) begin
                            n_valid[r_ev_idx] = 1'b0;
                        end
                    end

                    // last slot evaluated this cycle
                    if (!rd_more) begin
                        if ((r_cmd == ptsch_pkg::CMD_TICK) && !n_pend_vld) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH: begin
                push.vld       = 1'b1;
                push.item.last = 1'b1;
                case (r_cmd)
                    ptsch_pkg::CMD_TICK: begin
                        push.item.kind         = ptsch_pkg::KIND_FIRE;
                        push.item.result_ident = r_pend_id;
                        push.item.ok           = 1'b1;
                    end
                    ptsch_pkg::CMD_CREATE: begin
                        push.item.kind         = ptsch_pkg::KIND_CREATE;
                        push.item.result_ident = free_vld ? r_next_id : '0;
                        push.item.ok           = free_vld;
                    end
                    ptsch_pkg::CMD_DESTROY: begin
                        push.item.kind         = ptsch_pkg::KIND_DESTROY;
                        push.item.result_ident = r_ident;
                        push.item.ok           = r_found;
                    end
                    default: begin
                        push.item.kind         = ptsch_pkg::KIND_EXISTS;
                        push.item.result_ident = r_ident;
                        push.item.ok           = r_found;
                    end
                endcase

                if (push_rdy) begin
                    n_state = ST_IDLE;
                    // a create commits only once its reply is taken
                    if ((r_cmd == ptsch_pkg::CMD_CREATE) && free_vld) begin
                        ram_we             = 1'b1;
                        ram_waddr          = free_idx;
                        ram_wdata.ident    = r_next_id;
                        ram_wdata.deadline = r_now + {16'd0, r_delay};
                        ram_wdata.period   = r_period;
                        n_valid[free_idx]  = 1'b1;
                        // ids skip zero on wrap
                        n_next_id = (id_inc == '0) ? 32'd1 : id_inc;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_now      <= '0;
            r_next_id  <= 32'd1;
            r_valid    <= '0;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_next_id  <= n_next_id;
            r_valid    <= n_valid;
            r_rd_idx   <= n_rd_idx;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_cnt      <= n_cnt;
            r_found    <= n_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ev_idx  <= n_ev_idx;
        r_pend_id <= n_pend_id;
        if (accept) begin
            r_cmd    <= i_req.cmd;
            r_delay  <= i_req.delay_ms;
            r_period <= i_req.period_ms;
            r_ident  <= i_req.timer_ident;
        end
    end

    ptsch_ram #(
        .WIDTH (ptsch_pkg::SLOT_WORD_W),
        .DEPTH (NSLOT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    ptsch_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_push_rdy (push_rdy),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire
